[sv/bmap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmap_pkg
// Shared types, constants and helpers of the bitmap test/modify/search block.
// ----------------------------------------------------------------------------
package bmap_pkg;

	// bitmap geometry
	localparam int NBITS     = 1024;
	localparam int WORD_BITS = 32;
	localparam int NWORDS    = NBITS / WORD_BITS;
	localparam int IDX_W     = $clog2(NBITS);
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(NWORDS);
	localparam int LIM_W     = IDX_W + 1;
	localparam int CMD_W     = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TSET = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TCLR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TCHG = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FNZ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FNS  = 3'd4;

	// input word
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] bit_index;
	} in_item_t;

	// output word
	typedef struct packed {
		logic             old_bit;
		logic             found;
		logic [LIM_W-1:0] found_index;
	} out_item_t;

	// memory access from the sequencer
	typedef struct packed {
		logic [WADDR_W-1:0]   raddr;
		logic                 we;
		logic [WADDR_W-1:0]   waddr;
		logic [WORD_BITS-1:0] wdata;
	} mem_req_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SRCH,
		ST_DONE
	} st_t;

	// position of the lowest set bit of a word
	function automatic logic [POS_W-1:0] lsb_pos(input logic [WORD_BITS-1:0] w);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				p = POS_W'(i);
			end
		end
		return p;
	endfunction

endpackage

[sv/bmap_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmap_mem
// Bitmap word store: one read and one write port, registered read data,
// per-word valid bits so that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module bmap_mem import bmap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [NWORDS];
	logic [NWORDS-1:0]    vld_q;
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rvld_s1;

	// word array, no reset
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_s1 <= mem[req.raddr];
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			rvld_s1 <= vld_q[req.raddr];
		end
	end

	// never-written word reads as zero
	assign rdata = rvld_s1 ? rdata_s1 : '0;

endmodule

[sv/bmap_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmap_ctrl
// Command sequencer: read-modify-write of one word, or an upward scan that
// checks one bitmap word per cycle against start and limit masks.
// ----------------------------------------------------------------------------
module bmap_ctrl import bmap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	input  logic [LIM_W-1:0]     limit,
	output logic                 res_valid,
	input  logic                 res_ready,
	output out_item_t            res_data,
	output mem_req_t             mem_req,
	input  logic [WORD_BITS-1:0] mem_rdata
);

	st_t                  state_q, state_d;
	logic [CMD_W-1:0]     cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WADDR_W-1:0]   word_q;
	out_item_t            res_q;

	logic                 in_is_mod, in_is_srch, in_past_lim;
	logic [POS_W-1:0]     pos;
	logic [WORD_BITS-1:0] bit_mask, new_word;
	logic                 old_bit;
	logic [WADDR_W:0]     word_ext, lim_word;
	logic [WORD_BITS-1:0] tgt, start_mask, lim_mask, cand;
	logic                 hit, srch_end;
	logic [LIM_W-1:0]     next_base;

	// input decode
	assign in_is_mod   = (in_data.cmd == CMD_TSET) || (in_data.cmd == CMD_TCLR) ||
	                     (in_data.cmd == CMD_TCHG);
	assign in_is_srch  = (in_data.cmd == CMD_FNZ) || (in_data.cmd == CMD_FNS);
	assign in_past_lim = {1'b0, in_data.bit_index} >= limit;

	// modify path
	assign pos      = idx_q[POS_W-1:0];
	assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
	assign old_bit  = mem_rdata[pos];

	always_comb begin
		unique case (cmd_q)
			CMD_TSET: new_word = mem_rdata | bit_mask;
			CMD_TCLR: new_word = mem_rdata & ~bit_mask;
			default:  new_word = mem_rdata ^ bit_mask;
		endcase
	end

	// search path: mask the arriving word to [start, limit)
	assign word_ext   = {1'b0, word_q};
	assign lim_word   = limit[LIM_W-1:POS_W];
	assign tgt        = (cmd_q == CMD_FNS) ? mem_rdata : ~mem_rdata;
	assign start_mask = (word_q == idx_q[IDX_W-1:POS_W]) ?
	                    ({WORD_BITS{1'b1}} << idx_q[POS_W-1:0]) : {WORD_BITS{1'b1}};

	always_comb begin
		priority if (word_ext < lim_word) begin
			lim_mask = {WORD_BITS{1'b1}};
		end else if (word_ext == lim_word) begin
			lim_mask = ~({WORD_BITS{1'b1}} << limit[POS_W-1:0]);
		end else begin
			lim_mask = '0;
		end
	end

	assign cand      = tgt & start_mask & lim_mask;
	assign hit       = |cand;
	assign next_base = {word_ext + 1'b1, {POS_W{1'b0}}};
	assign srch_end  = hit || (next_base >= limit);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (in_is_mod) begin
						state_d = ST_MOD;
					end else if (in_is_srch && !in_past_lim) begin
						state_d = ST_SRCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MOD: begin
				state_d = ST_DONE;
			end
			ST_SRCH: begin
				if (srch_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = 1'b1;
		res_valid      = 1'b0;
		mem_req.raddr  = word_q;
		mem_req.we     = 1'b0;
		mem_req.waddr  = idx_q[IDX_W-1:POS_W];
		mem_req.wdata  = new_word;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				mem_req.raddr = in_data.bit_index[IDX_W-1:POS_W];
			end
			ST_MOD: begin
				mem_req.we = 1'b1;
			end
			ST_SRCH: begin
				mem_req.raddr = word_q + 1'b1;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign res_data = res_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command, word pointer and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q             <= in_data.cmd;
					idx_q             <= in_data.bit_index;
					word_q            <= in_data.bit_index[IDX_W-1:POS_W];
					res_q.old_bit     <= 1'b0;
					res_q.found       <= 1'b0;
					res_q.found_index <= in_is_srch ? limit : '0;
				end
			end
			ST_MOD: begin
				res_q.old_bit <= old_bit;
			end
			ST_SRCH: begin
				word_q <= word_q + 1'b1;
				if (hit) begin
					res_q.found       <= 1'b1;
					res_q.found_index <= {1'b0, word_q, lsb_pos(cand)};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// an accepted word always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted word left sequencer idle");

	// a found index lies below the limit
	a_found_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.found) |-> (res_data.found_index < limit))
		else $error("found index not below search limit");

	// scan walks one word per cycle
	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH && !srch_end) |=>
		(state_q == ST_SRCH && word_q == $past(word_q) + 1'b1))
		else $error("scan pointer skipped a word");

	// a handed-off result frees the sequencer
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (state_q == ST_IDLE))
		else $error("sequencer stuck after result hand-off");
`endif

endmodule

[sv/bitmap_test_modify_and_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_test_modify_and_search
// Bitmap of 1024 bits with test-and-set/clear/change and find-next-zero/set.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_stall/in_data: one command word at a time;
//   in_stall is high while a command is in work
// - output channel out_valid/out_stall/out_data: one result word per command,
//   held in an output register until taken, so a new command is accepted
//   while a result still waits
// - cfg_we/cfg_wdata write the search limit; write only while idle
// - modify commands: the word is read, then written back, and the result
//   goes to the output register; the next command may enter after hand-off
// - searches: the scan covers 1 to 32 words and checks one 32-bit word
//   per cycle through the single read port, ending at the first hit or at
//   the limit
// - a search starting at or past the limit, or an unused code, goes
//   straight to the result without a read-modify-write or scan
// - reset clears the whole bitmap at once through per-word valid bits and
//   sets the search limit to 1024; no clearing pass is needed
// - when out_stall holds a result, the next command still runs and then
//   waits for the output register before its result is loaded
// ----------------------------------------------------------------------------
module bitmap_test_modify_and_search import bmap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	logic [LIM_W-1:0]     search_limit_q;
	logic [LIM_W-1:0]     limit;
	logic                 res_valid, res_ready;
	out_item_t            res_data;
	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] mem_rdata;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	// search limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_limit_q <= LIM_W'(NBITS);
		end else if (cfg_we) begin
			search_limit_q <= cfg_wdata;
		end
	end

	// clamp the limit to the bitmap size
	assign limit = (search_limit_q > LIM_W'(NBITS)) ? LIM_W'(NBITS) : search_limit_q;

	bmap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.limit     (limit),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	bmap_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	// output register takes a result when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
